@@ src/psst_pkg.sv @@
// Shared types, codes and sizes for the packed sparse-set table.
package psst_pkg;

  localparam int ENTRIES = 1024;
  localparam int ID_W    = 10;
  localparam int SLOT_W  = $clog2(ENTRIES);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int EB_W    = 13;
  localparam int OFF_W   = 22;
  localparam int FUNC_W  = 2;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(ENTRIES);

  typedef enum logic [FUNC_W-1:0] {
    FN_INSERT = 2'd0,
    FN_REMOVE = 2'd1,
    FN_LOOKUP = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_ABSENT  = 2'd2,
    ST_PRESENT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_LOOK,
    S_MULD,
    S_MULS,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              valid;
    logic [SLOT_W-1:0] slot;
  } e2s_entry_t;

  typedef struct packed {
    logic            we;
    logic [ID_W-1:0] addr;
    e2s_entry_t      data;
  } e2s_wr_t;

  typedef struct packed {
    logic              we;
    logic [SLOT_W-1:0] addr;
    logic [ID_W-1:0]   data;
  } s2e_wr_t;

endpackage

@@ src/psst_e2s_mem.sv @@
// Entity-to-slot map memory with a clearing sweep after reset.
module psst_e2s_mem
  import psst_pkg::*;
(
  input  logic            clk,
  input  logic            rst_n,
  input  logic [ID_W-1:0] rd_addr,
  input  e2s_wr_t         wr,
  output e2s_entry_t      rd_data,
  output logic            clr_done
);

  e2s_entry_t      mem [2**ID_W];
  logic [ID_W:0]   clr_r;
  logic [ID_W:0]   clr_nxt;
  e2s_entry_t      rd_data_r;

  assign clr_done = clr_r[ID_W];
  assign clr_nxt  = clr_done ? clr_r : clr_r + 1'b1;
  assign rd_data  = rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else begin
      clr_r <= clr_nxt;
    end
  end

  // Sweep one entry a cycle until every entity reads as absent.
  always_ff @(posedge clk) begin
    if (!clr_done) begin
      mem[clr_r[ID_W-1:0]] <= '0;
    end else if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

@@ src/psst_s2e_mem.sv @@
// Slot-to-entity map memory, contents undefined until written.
module psst_s2e_mem
  import psst_pkg::*;
(
  input  logic              clk,
  input  logic [SLOT_W-1:0] rd_addr,
  input  s2e_wr_t           wr,
  output logic [ID_W-1:0]   rd_data
);

  logic [ID_W-1:0] mem [ENTRIES];
  logic [ID_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

endmodule

@@ src/psst_off_mul.sv @@
// Registered slot-times-record-size multiplier for byte offsets.
module psst_off_mul
  import psst_pkg::*;
(
  input  logic              clk,
  input  logic [SLOT_W-1:0] slot,
  input  logic [EB_W-1:0]   elem_bytes,
  output logic [OFF_W-1:0]  prod
);

  logic [SLOT_W+EB_W-1:0] full;
  logic [OFF_W-1:0]       prod_r;

  assign full = {{EB_W{1'b0}}, slot} * {{SLOT_W{1'b0}}, elem_bytes};
  assign prod = prod_r;

  // Keep the low bits; larger offsets wrap.
  always_ff @(posedge clk) begin
    prod_r <= full[OFF_W-1:0];
  end

endmodule

@@ src/packed_sparse_set_table_top.sv @@
// Flow: an input transfer goes through S_LOOK, S_MULD, S_MULS and S_OUT, which holds
//   until the output is free, before the result is registered as valid; one operation in
//   flight, covering the read, map update, second map write and two offset multiplies.
// Reset: synchronous, active low; the entity map is then swept clear of all 1024
//   entries with in_ready low. Config writes are taken during the sweep.
// Top level: control sequencer of the packed sparse-set table.
module packed_sparse_set_table_top
  import psst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [EB_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [ID_W-1:0]   in_entity_id,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [SLOT_W-1:0] out_slot,
  output logic [OFF_W-1:0]  out_byte_offset,
  output logic              out_move_needed,
  output logic [OFF_W-1:0]  out_move_source_offset,
  output logic [ID_W-1:0]   out_moved_entity,
  output logic [CNT_W-1:0]  out_occupancy
);

  state_t            state_r, state_nxt;
  logic [EB_W-1:0]   eb_r;
  logic [CNT_W-1:0]  used_r, used_nxt;
  func_t             func_r;
  logic [ID_W-1:0]   eid_r;
  status_t           status_r, status_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [SLOT_W-1:0] last_r, last_nxt;
  logic [ID_W-1:0]   ment_r, ment_nxt;
  logic              move_r, move_nxt;
  logic [OFF_W-1:0]  boff_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [SLOT_W-1:0] out_slot_r;
  logic [OFF_W-1:0]  out_boff_r;
  logic              out_move_r;
  logic [OFF_W-1:0]  out_msrc_r;
  logic [ID_W-1:0]   out_ment_r;
  logic [CNT_W-1:0]  out_occ_r;

  logic              in_xfer;
  logic              out_free;
  logic              load_out;
  logic              clr_done;
  logic [CNT_W-1:0]  used_m1;
  e2s_entry_t        e2s_rd;
  e2s_wr_t           e2s_wr;
  s2e_wr_t           s2e_wr;
  logic [ID_W-1:0]   s2e_rd;
  logic [SLOT_W-1:0] mul_a;
  logic [OFF_W-1:0]  mul_p;

  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;
  assign used_m1  = used_r - 1'b1;

  psst_e2s_mem u_e2s (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_addr  (in_entity_id),
    .wr       (e2s_wr),
    .rd_data  (e2s_rd),
    .clr_done (clr_done)
  );

  psst_s2e_mem u_s2e (
    .clk     (clk),
    .rd_addr (used_m1[SLOT_W-1:0]),
    .wr      (s2e_wr),
    .rd_data (s2e_rd)
  );

  psst_off_mul u_mul (
    .clk        (clk),
    .slot       (mul_a),
    .elem_bytes (eb_r),
    .prod       (mul_p)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_INIT:  if (clr_done) state_nxt = S_IDLE;
      S_IDLE:  if (in_valid) state_nxt = S_LOOK;
      S_LOOK:  state_nxt = S_MULD;
      S_MULD:  state_nxt = S_MULS;
      S_MULS:  state_nxt = S_OUT;
      S_OUT:   if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_INIT;
    endcase
  end

  // Outputs and map updates per state.
  always_comb begin
    in_ready   = 1'b0;
    load_out   = 1'b0;
    mul_a      = last_r;
    e2s_wr     = '0;
    s2e_wr     = '0;
    used_nxt   = used_r;
    status_nxt = status_r;
    slot_nxt   = slot_r;
    last_nxt   = last_r;
    ment_nxt   = ment_r;
    move_nxt   = move_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
      end
      S_LOOK: begin
        // Undefined fields report zero, so zero slot and last give zero offsets.
        status_nxt = ST_OK;
        slot_nxt   = '0;
        last_nxt   = '0;
        ment_nxt   = '0;
        move_nxt   = 1'b0;
        case (func_r)
          FN_INSERT: begin
            if (e2s_rd.valid) begin
              status_nxt = ST_PRESENT;
            end else if (used_r == CNT_FULL) begin
              status_nxt = ST_FULL;
            end else begin
              e2s_wr.we         = 1'b1;
              e2s_wr.addr       = eid_r;
              e2s_wr.data.valid = 1'b1;
              e2s_wr.data.slot  = used_r[SLOT_W-1:0];
              s2e_wr.we         = 1'b1;
              s2e_wr.addr       = used_r[SLOT_W-1:0];
              s2e_wr.data       = eid_r;
              used_nxt          = used_r + 1'b1;
              slot_nxt          = used_r[SLOT_W-1:0];
            end
          end
          FN_REMOVE: begin
            if (!e2s_rd.valid) begin
              status_nxt = ST_ABSENT;
            end else begin
              slot_nxt    = e2s_rd.slot;
              used_nxt    = used_m1;
              e2s_wr.we   = 1'b1;
              e2s_wr.addr = eid_r;
              // Swap the last entity into the freed slot.
              if (e2s_rd.slot != used_m1[SLOT_W-1:0]) begin
                move_nxt    = 1'b1;
                last_nxt    = used_m1[SLOT_W-1:0];
                ment_nxt    = s2e_rd;
                s2e_wr.we   = 1'b1;
                s2e_wr.addr = e2s_rd.slot;
                s2e_wr.data = s2e_rd;
              end
            end
          end
          FN_LOOKUP: begin
            if (!e2s_rd.valid) begin
              status_nxt = ST_ABSENT;
            end else begin
              slot_nxt = e2s_rd.slot;
            end
          end
          default: begin
          end
        endcase
      end
      S_MULD: begin
        mul_a = slot_r;
        // Repoint the moved entity at its new slot.
        if (move_r) begin
          e2s_wr.we         = 1'b1;
          e2s_wr.addr       = ment_r;
          e2s_wr.data.valid = 1'b1;
          e2s_wr.data.slot  = slot_r;
        end
      end
      S_OUT: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      eb_r        <= EB_W'(1);
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      if (cfg_we) begin
        eb_r <= cfg_wdata;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      func_r <= func_t'(in_func);
      eid_r  <= in_entity_id;
    end
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    last_r   <= last_nxt;
    ment_r   <= ment_nxt;
    move_r   <= move_nxt;
    if (state_r == S_MULS) begin
      boff_r <= mul_p;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_slot_r   <= slot_r;
      out_boff_r   <= boff_r;
      out_move_r   <= move_r;
      out_msrc_r   <= mul_p;
      out_ment_r   <= ment_r;
      out_occ_r    <= used_r;
    end
  end

  assign out_valid              = out_valid_r;
  assign out_status             = out_status_r;
  assign out_slot               = out_slot_r;
  assign out_byte_offset        = out_boff_r;
  assign out_move_needed        = out_move_r;
  assign out_move_source_offset = out_msrc_r;
  assign out_moved_entity       = out_ment_r;
  assign out_occupancy          = out_occ_r;

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CNT_FULL)
    else $error("occupancy exceeds table size");

  a_no_write_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (e2s_wr.we || s2e_wr.we) |-> clr_done)
    else $error("map write during clearing sweep");

  a_move_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MULD && move_r) |-> (status_r == ST_OK && func_r == FN_REMOVE))
    else $error("move on a failed or non-remove operation");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_LOOK) |=> (used_r == $past(used_r)))
    else $error("count changed outside the update cycle");

endmodule
